@@ rtl/quaternion_arithmetic_unit_macros.svh @@
// Assertion shorthands, clocked on clk and cleared by arst_n
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define QAU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QAU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/qau_pkg.sv @@
`timescale 1ns / 1ps
package qau_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int FRACTION_BITS_DEF = 12;

	typedef enum logic [1:0] {
		FN_QMUL = 2'd0,
		FN_VMUL = 2'd1,
		FN_CONJ = 2'd2,
		FN_NORM = 2'd3
	} func_t;

	typedef logic [1:0] idx_t;

	// Hamilton product: result k is the sum over j of +/- a[HA_A] * b[HA_B]
	// index order w, x, y, z
	localparam idx_t HA_A [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd2, 2'd3},
		'{2'd2, 2'd0, 2'd3, 2'd1},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam idx_t HA_B [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd3, 2'd2},
		'{2'd0, 2'd2, 2'd1, 2'd3},
		'{2'd0, 2'd3, 2'd2, 2'd1}
	};
	localparam logic HA_NEG [4][4] = '{
		'{1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1}
	};

endpackage

@@ rtl/quaternion_arithmetic_unit.sv @@
// Quaternion product, vector product, conjugate and normalise, fully pipelined.
// Every operation passes through the same pipeline stages, whatever the function.
// Throughput: one transaction per cycle; a stalled output freezes the whole pipeline.
// The depth is set by the 32-step square root and the FRACTION_BITS + 2 step dividers.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
`include "quaternion_arithmetic_unit_macros.svh"
module quaternion_arithmetic_unit #(
	parameter int COMPONENT_WIDTH = qau_pkg::COMPONENT_WIDTH_DEF,
	parameter int FRACTION_BITS = qau_pkg::FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] func,
	input  logic signed [COMPONENT_WIDTH-1:0] a_w,
	input  logic signed [COMPONENT_WIDTH-1:0] a_x,
	input  logic signed [COMPONENT_WIDTH-1:0] a_y,
	input  logic signed [COMPONENT_WIDTH-1:0] a_z,
	input  logic signed [COMPONENT_WIDTH-1:0] b_w,
	input  logic signed [COMPONENT_WIDTH-1:0] b_x,
	input  logic signed [COMPONENT_WIDTH-1:0] b_y,
	input  logic signed [COMPONENT_WIDTH-1:0] b_z,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [COMPONENT_WIDTH-1:0] r_w,
	output logic signed [COMPONENT_WIDTH-1:0] r_x,
	output logic signed [COMPONENT_WIDTH-1:0] r_y,
	output logic signed [COMPONENT_WIDTH-1:0] r_z,
	output logic saturated,
	output logic zero_length
);

	localparam int CW = COMPONENT_WIDTH;
	localparam int F = FRACTION_BITS;
	localparam int PW = 2 * CW;
	localparam int WW = 2 * CW + 3;
	localparam int SW = 66;
	localparam int NSQ = 32;
	localparam int RW = 36;
	localparam int NDV = F + 2;
	localparam logic [NDV-1:0] QMAX = {1'b1, {(NDV-1){1'b0}}};

	typedef logic signed [CW-1:0] comp_t;

	typedef struct packed {
		logic norm;
		logic ovf;
		logic zero;
		logic [3:0] neg;
		logic sat;
		logic [3:0][CW-1:0] r;
	} side_t;

	function automatic logic [CW:0] clip_f(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] hi;
		logic signed [WW-1:0] lo;
		hi = {{(WW-CW+1){1'b0}}, {(CW-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			clip_f = {1'b1, hi[CW-1:0]};
		end else if (v < lo) begin
			clip_f = {1'b1, lo[CW-1:0]};
		end else begin
			clip_f = {1'b0, v[CW-1:0]};
		end
	endfunction

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- stage 1: products and squares
	comp_t a_in [4];
	comp_t b_in [4];
	logic [CW-1:0] mag_in [4];

	assign a_in[0] = a_w;
	assign a_in[1] = a_x;
	assign a_in[2] = a_y;
	assign a_in[3] = a_z;
	assign b_in[0] = (func == qau_pkg::FN_VMUL) ? '0 : b_w;
	assign b_in[1] = b_x;
	assign b_in[2] = b_y;
	assign b_in[3] = b_z;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mag_in[k] = a_in[k][CW-1] ? CW'(-a_in[k]) : CW'(a_in[k]);
		end
	end

	logic vld_s1;
	qau_pkg::func_t func_s1;
	logic signed [PW-1:0] prod_s1 [4][4];
	logic [PW-1:0] sqr_s1 [4];
	logic [CW-1:0] mag_s1 [4];
	comp_t a_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= qau_pkg::func_t'(func);
			for (int k = 0; k < 4; k++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[k][j] <= a_in[qau_pkg::HA_A[k][j]] * b_in[qau_pkg::HA_B[k][j]];
				end
				sqr_s1[k] <= PW'(mag_in[k]) * PW'(mag_in[k]);
				mag_s1[k] <= mag_in[k];
				a_s1[k] <= a_in[k];
			end
		end
	end

	// ---------------- stage 2: sums with rounding, conjugate
	logic signed [WW-1:0] hsum [4];
	logic [SW-1:0] ssum;
	comp_t conj [4];
	logic csat;

	always_comb begin
		logic signed [WW-1:0] acc;
		logic signed [WW-1:0] term;
		for (int k = 0; k < 4; k++) begin
			acc = {{(WW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
			for (int j = 0; j < 4; j++) begin
				term = WW'(prod_s1[k][j]);
				acc = qau_pkg::HA_NEG[k][j] ? acc - term : acc + term;
			end
			hsum[k] = acc >>> F;
		end
		ssum = '0;
		for (int k = 0; k < 4; k++) begin
			ssum = ssum + SW'(sqr_s1[k]);
		end
		conj[0] = a_s1[0];
		csat = 1'b0;
		for (int k = 1; k < 4; k++) begin
			if (a_s1[k] == {1'b1, {(CW-1){1'b0}}}) begin
				conj[k] = {1'b0, {(CW-1){1'b1}}};
				csat = 1'b1;
			end else begin
				conj[k] = -a_s1[k];
			end
		end
	end

	logic vld_s2;
	qau_pkg::func_t func_s2;
	logic signed [WW-1:0] hsum_s2 [4];
	logic [SW-1:0] ssum_s2;
	comp_t conj_s2 [4];
	logic csat_s2;
	logic [CW-1:0] mag_s2 [4];
	logic [3:0] neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			hsum_s2 <= hsum;
			ssum_s2 <= ssum;
			conj_s2 <= conj;
			csat_s2 <= csat;
			mag_s2 <= mag_s1;
			for (int k = 0; k < 4; k++) begin
				neg_s2[k] <= a_s1[k][CW-1];
			end
		end
	end

	// ---------------- stage 3: clip products, classify, normalising shift count
	side_t side3;
	logic [4:0] lz_pairs;

	always_comb begin
		logic [CW:0] c;
		side3.norm = (func_s2 == qau_pkg::FN_NORM);
		side3.ovf = |ssum_s2[SW-1:64];
		side3.zero = (ssum_s2 == '0);
		side3.neg = neg_s2;
		side3.sat = 1'b0;
		for (int k = 0; k < 4; k++) begin
			c = clip_f(hsum_s2[k]);
			if (func_s2 == qau_pkg::FN_CONJ) begin
				side3.r[k] = conj_s2[k];
			end else begin
				side3.r[k] = c[CW-1:0];
				side3.sat = side3.sat | c[CW];
			end
		end
		if (func_s2 == qau_pkg::FN_CONJ) begin
			side3.sat = csat_s2;
		end
		// highest non-zero bit pair decides the shift
		lz_pairs = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (|ssum_s2[2*i+1 -: 2]) begin
				lz_pairs = 5'(31 - i);
			end
		end
	end

	logic vld_s3;
	side_t side_s3;
	logic [63:0] s_s3;
	logic [4:0] e_s3;
	logic [CW-1:0] mag_s3 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side3;
			s_s3 <= ssum_s2[63:0];
			e_s3 <= lz_pairs;
			mag_s3 <= mag_s2;
		end
	end

	// ---------------- stage 4: normalising shift
	logic vld_s4;
	side_t side_s4;
	logic [63:0] sh_s4;
	logic [32:0] nn_s4 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			sh_s4 <= s_s3 << {e_s3, 1'b0};
			for (int k = 0; k < 4; k++) begin
				nn_s4[k] <= 33'(mag_s3[k]) << e_s3;
			end
		end
	end

	// ---------------- square root, one result bit per stage
	logic vld_sq [NSQ];
	side_t side_sq [NSQ];
	logic [63:0] rad_sq [NSQ];
	logic [RW-1:0] rem_sq [NSQ];
	logic [31:0] root_sq [NSQ];
	logic [32:0] nn_sq [NSQ][4];

	for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
		logic vld_in;
		side_t side_in;
		logic [63:0] rad_in;
		logic [RW-1:0] rem_in;
		logic [31:0] root_in;
		logic [32:0] nn_in [4];
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		logic ge;

		if (g == 0) begin : g_first
			assign vld_in = vld_s4;
			assign side_in = side_s4;
			assign rad_in = sh_s4;
			assign rem_in = '0;
			assign root_in = '0;
			assign nn_in = nn_s4;
		end else begin : g_next
			assign vld_in = vld_sq[g-1];
			assign side_in = side_sq[g-1];
			assign rad_in = rad_sq[g-1];
			assign rem_in = rem_sq[g-1];
			assign root_in = root_sq[g-1];
			assign nn_in = nn_sq[g-1];
		end

		assign rem_sh = {rem_in[RW-3:0], rad_in[63:62]};
		assign trial = RW'({root_in, 2'b01});
		assign ge = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq[g] <= 1'b0;
			end else if (en) begin
				vld_sq[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sq[g] <= side_in;
				rad_sq[g] <= rad_in << 2;
				rem_sq[g] <= ge ? rem_sh - trial : rem_sh;
				root_sq[g] <= {root_in[30:0], ge};
				nn_sq[g] <= nn_in;
			end
		end
	end

	// ---------------- four restoring dividers, one quotient bit per stage
	logic vld_dv [NDV];
	side_t side_dv [NDV];
	logic [31:0] len_dv [NDV];
	logic [32:0] rem_dv [NDV][4];
	logic [NDV-1:0] q_dv [NDV][4];

	for (genvar g = 0; g < NDV; g++) begin : g_div
		logic vld_in;
		side_t side_in;
		logic [31:0] len_in;
		logic [32:0] rem_nx [4];
		logic [NDV-1:0] q_nx [4];

		if (g == 0) begin : g_first
			assign vld_in = vld_sq[NSQ-1];
			assign side_in = side_sq[NSQ-1];
			assign len_in = root_sq[NSQ-1];
			always_comb begin
				logic ge;
				for (int k = 0; k < 4; k++) begin
					ge = (nn_sq[NSQ-1][k] >= 33'(len_in));
					rem_nx[k] = ge ? nn_sq[NSQ-1][k] - 33'(len_in) : nn_sq[NSQ-1][k];
					q_nx[k] = NDV'(ge);
				end
			end
		end else begin : g_next
			assign vld_in = vld_dv[g-1];
			assign side_in = side_dv[g-1];
			assign len_in = len_dv[g-1];
			always_comb begin
				logic [32:0] r2;
				logic ge;
				for (int k = 0; k < 4; k++) begin
					r2 = {rem_dv[g-1][k][31:0], 1'b0};
					ge = (r2 >= 33'(len_in));
					rem_nx[k] = ge ? r2 - 33'(len_in) : r2;
					q_nx[k] = {q_dv[g-1][k][NDV-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv[g] <= 1'b0;
			end else if (en) begin
				vld_dv[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_dv[g] <= side_in;
				len_dv[g] <= len_in;
				rem_dv[g] <= rem_nx;
				q_dv[g] <= q_nx;
			end
		end
	end

	// ---------------- output stage: round quotient, sign, select
	comp_t res [4];
	logic res_sat;
	logic res_zl;

	always_comb begin
		side_t sd;
		logic [NDV:0] q1;
		logic signed [WW-1:0] v;
		logic [CW:0] c;
		sd = side_dv[NDV-1];
		res_sat = 1'b0;
		res_zl = 1'b0;
		for (int k = 0; k < 4; k++) begin
			q1 = (NDV+1)'(q_dv[NDV-1][k]) + 1'b1;
			v = WW'(q1[NDV:1]);
			if (sd.neg[k]) begin
				v = -v;
			end
			if (sd.ovf) begin
				// every component exactly minus one half
				v = -(WW'(1) <<< (F - 1));
			end
			c = clip_f(v);
			if (!sd.norm) begin
				res[k] = sd.r[k];
			end else if (sd.zero) begin
				res[k] = '0;
			end else begin
				res[k] = c[CW-1:0];
				res_sat = res_sat | c[CW];
			end
		end
		if (!sd.norm) begin
			res_sat = sd.sat;
		end else begin
			res_zl = sd.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_dv[NDV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_w <= res[0];
			r_x <= res[1];
			r_y <= res[2];
			r_z <= res[3];
			saturated <= res_sat;
			zero_length <= res_zl;
		end
	end

	`QAU_ASSERT_IMP(a_zero_clean, out_valid && zero_length, r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0 && !saturated, "zero quaternion gave non-zero result")
	`QAU_ASSERT_IMP(a_root_normalised, vld_dv[0] && side_dv[0].norm && !side_dv[0].zero && !side_dv[0].ovf, len_dv[0][31], "square root lost its top bit")
	`QAU_ASSERT_IMP(a_quot_bound, vld_dv[NDV-1] && side_dv[NDV-1].norm && !side_dv[NDV-1].zero, q_dv[NDV-1][0] <= QMAX && q_dv[NDV-1][1] <= QMAX, "quotient above one")
	`QAU_ASSERT_NXT(a_stall_freeze, out_valid && !out_ready, out_valid && $stable(r_w) && $stable(zero_length), "output moved while stalled")

endmodule
